/* src/step_timing_statistics_macros.svh */
// assertion macros for the step timing statistics checker
`ifndef STEP_TIMING_STATISTICS_MACROS_SVH
`define STEP_TIMING_STATISTICS_MACROS_SVH

// same-cycle implication
`define STS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("step timing statistics check failed");

// next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("step timing statistics check failed");

`endif

/* src/sts_pkg.sv */
// types and constants of the step timing statistics block
package sts_pkg;

	localparam int TimeWidth  = 32;
	localparam int StampWidth = 63;
	localparam int SumWidth   = 64;
	localparam int FracBits   = 8;
	localparam int MeanWidth  = 40;
	localparam int DivSteps   = MeanWidth;
	localparam int StepCntW   = $clog2(DivSteps);

	localparam logic [TimeWidth-1:0] PeriodReset = TimeWidth'(1000);

	typedef struct packed {
		logic [TimeWidth-1:0]  step_time;
		logic [TimeWidth-1:0]  round_trip_time;
		logic [StampWidth-1:0] scheduled_time;
		logic [StampWidth-1:0] completion_time;
	} in_item_t;

	typedef struct packed {
		logic [TimeWidth-1:0] min_step;
		logic [TimeWidth-1:0] max_step;
		logic [TimeWidth-1:0] min_round_trip;
		logic [TimeWidth-1:0] max_round_trip;
		logic [MeanWidth-1:0] mean_step;
		logic [MeanWidth-1:0] mean_round_trip;
		logic [TimeWidth-1:0] miss_count;
		logic [TimeWidth-1:0] worst_lateness;
		logic [TimeWidth-1:0] step_count;
	} out_item_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACC  = 8'b0000_0010,
		ST_LATE = 8'b0000_0100,
		ST_MISS = 8'b0000_1000,
		ST_LOAD = 8'b0001_0000,
		ST_CHK  = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

endpackage

/* src/sts_if.sv */
// handshake channel interfaces of the step timing statistics block
interface sts_in_if;
	logic               valid;
	logic               ready;
	sts_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_out_if;
	logic               valid;
	logic               ready;
	sts_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sts_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sts_pkg::TimeWidth-1:0]      data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/step_timing_statistics.sv */
// step timing statistics: running extrema, means, deadline misses and step count
// One item (step time, round-trip time, scheduled start, completion stamp) is taken when
// sample.ready is high; ready then stays low until the item's statistics are loaded into
// the output register, so a new item is taken only after the last one is through.
// Both means come from one shared 32-bit restoring divider step, 40 quotient bits per mean
// plus a load and an overflow check each; a mean whose quotient overflows 40 bits skips its
// steps and saturates. The result waits in the output register until taken while the next
// item is already being worked on.
// The period register is to be written through cfg only while the block is idle; the block
// itself does not enforce this, and cfg.ready is always high.
module step_timing_statistics (
	input  logic  clk,
	input  logic  arst_n,
	sts_in_if.sink    sample,
	sts_out_if.source stats,
	sts_cfg_if.sink   cfg
);

	localparam int TW = sts_pkg::TimeWidth;
	localparam int SW = sts_pkg::SumWidth;
	localparam int MW = sts_pkg::MeanWidth;
	localparam int FB = sts_pkg::FracBits;

	sts_pkg::state_t state_q;

	logic [TW-1:0] period_q;
	sts_pkg::in_item_t item_q;

	logic [TW-1:0] min_step_q, max_step_q, min_rtt_q, max_rtt_q;
	logic [SW-1:0] step_sum_q, rtt_sum_q;
	logic [TW-1:0] miss_q, late_max_q, count_q;
	logic [SW-1:0] deadline_q;
	logic          missed_q;
	logic [TW-1:0] late_q;

	logic                         sel_q;
	logic [TW-1:0]                rem_q;
	logic [MW-1:0]                sh_q;
	logic [MW-1:0]                quo_q;
	logic [sts_pkg::StepCntW-1:0] cnt_q;
	logic [MW-1:0]                mean_step_q;
	logic [MW-1:0]                mean_rtt_q;

	logic               out_valid_q;
	sts_pkg::out_item_t out_q;

	logic [SW:0]   step_add, rtt_add, late_diff;
	logic [SW-1:0] cur_sum;
	logic [TW:0]   unit_a;
	logic [TW+1:0] unit_diff;
	logic          unit_ge;
	logic [MW-1:0] div_result;
	logic          first;

	assign sample.ready = state_q == sts_pkg::ST_IDLE;
	assign cfg.ready    = 1'b1;
	assign stats.valid  = out_valid_q;
	assign stats.data   = out_q;

	assign first     = count_q == '0;
	assign step_add  = {1'b0, step_sum_q} + {{(SW-TW+1){1'b0}}, item_q.step_time};
	assign rtt_add   = {1'b0, rtt_sum_q} + {{(SW-TW+1){1'b0}}, item_q.round_trip_time};
	assign late_diff = {{(SW-sts_pkg::StampWidth+1){1'b0}}, item_q.completion_time}
		- {1'b0, deadline_q};
	assign cur_sum   = sel_q ? rtt_sum_q : step_sum_q;

	// shared subtractor: overflow check on the high half, then one quotient bit a cycle
	always_comb begin
		if (state_q == sts_pkg::ST_CHK) begin
			unit_a = {1'b0, rem_q};
		end else begin
			unit_a = {rem_q, sh_q[$high(sh_q)]};
		end
		unit_diff = {1'b0, unit_a} - {2'b0, count_q};
		unit_ge   = !unit_diff[TW+1];
	end

	assign div_result = {quo_q[MW-2:0], unit_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= sts_pkg::PeriodReset;
		end else if (cfg.valid) begin
			period_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			min_step_q  <= '0;
			max_step_q  <= '0;
			min_rtt_q   <= '0;
			max_rtt_q   <= '0;
			step_sum_q  <= '0;
			rtt_sum_q   <= '0;
			miss_q      <= '0;
			late_max_q  <= '0;
			count_q     <= '0;
			sel_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (stats.valid && stats.ready && state_q != sts_pkg::ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				sts_pkg::ST_IDLE: begin
					if (sample.valid) begin
						state_q <= sts_pkg::ST_ACC;
					end
				end
				sts_pkg::ST_ACC: begin
					if (first || item_q.step_time < min_step_q) begin
						min_step_q <= item_q.step_time;
					end
					if (first || item_q.step_time > max_step_q) begin
						max_step_q <= item_q.step_time;
					end
					if (first || item_q.round_trip_time < min_rtt_q) begin
						min_rtt_q <= item_q.round_trip_time;
					end
					if (first || item_q.round_trip_time > max_rtt_q) begin
						max_rtt_q <= item_q.round_trip_time;
					end
					step_sum_q <= step_add[SW] ? '1 : step_add[SW-1:0];
					rtt_sum_q  <= rtt_add[SW] ? '1 : rtt_add[SW-1:0];
					if (count_q != '1) begin
						count_q <= count_q + TW'(1);
					end
					state_q <= sts_pkg::ST_LATE;
				end
				sts_pkg::ST_LATE: begin
					state_q <= sts_pkg::ST_MISS;
				end
				sts_pkg::ST_MISS: begin
					if (missed_q) begin
						if (miss_q != '1) begin
							miss_q <= miss_q + TW'(1);
						end
						if (late_q > late_max_q) begin
							late_max_q <= late_q;
						end
					end
					sel_q   <= 1'b0;
					state_q <= sts_pkg::ST_LOAD;
				end
				sts_pkg::ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= sts_pkg::ST_CHK;
				end
				sts_pkg::ST_CHK: begin
					if (unit_ge) begin
						// quotient does not fit in the mean field
						if (sel_q) begin
							state_q <= sts_pkg::ST_FIN;
						end else begin
							sel_q   <= 1'b1;
							state_q <= sts_pkg::ST_LOAD;
						end
					end else begin
						state_q <= sts_pkg::ST_DIV;
					end
				end
				sts_pkg::ST_DIV: begin
					cnt_q <= cnt_q + sts_pkg::StepCntW'(1);
					if (cnt_q == sts_pkg::StepCntW'(sts_pkg::DivSteps - 1)) begin
						if (sel_q) begin
							state_q <= sts_pkg::ST_FIN;
						end else begin
							sel_q   <= 1'b1;
							state_q <= sts_pkg::ST_LOAD;
						end
					end
				end
				sts_pkg::ST_FIN: begin
					if (!out_valid_q || stats.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= sts_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sts_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == sts_pkg::ST_IDLE && sample.valid) begin
			item_q <= sample.data;
		end
		if (state_q == sts_pkg::ST_ACC) begin
			deadline_q <= {1'b0, item_q.scheduled_time} + {{(SW-TW){1'b0}}, period_q};
		end
		if (state_q == sts_pkg::ST_LATE) begin
			missed_q <= !late_diff[SW] && (late_diff[SW-1:0] != '0);
			late_q   <= (late_diff[SW-1:TW] != '0) ? '1 : late_diff[TW-1:0];
		end
		if (state_q == sts_pkg::ST_LOAD) begin
			rem_q <= cur_sum[SW-1:SW-TW];
			sh_q  <= {cur_sum[SW-TW-1:0], {FB{1'b0}}};
		end
		if (state_q == sts_pkg::ST_CHK && unit_ge) begin
			if (sel_q) begin
				mean_rtt_q <= '1;
			end else begin
				mean_step_q <= '1;
			end
		end
		if (state_q == sts_pkg::ST_DIV) begin
			rem_q <= unit_ge ? unit_diff[TW-1:0] : unit_a[TW-1:0];
			sh_q  <= {sh_q[$high(sh_q)-1:0], 1'b0};
			quo_q <= div_result;
			if (cnt_q == sts_pkg::StepCntW'(sts_pkg::DivSteps - 1)) begin
				if (sel_q) begin
					mean_rtt_q <= div_result;
				end else begin
					mean_step_q <= div_result;
				end
			end
		end
		if (state_q == sts_pkg::ST_FIN && (!out_valid_q || stats.ready)) begin
			out_q.min_step        <= min_step_q;
			out_q.max_step        <= max_step_q;
			out_q.min_round_trip  <= min_rtt_q;
			out_q.max_round_trip  <= max_rtt_q;
			out_q.mean_step       <= mean_step_q;
			out_q.mean_round_trip <= mean_rtt_q;
			out_q.miss_count      <= miss_q;
			out_q.worst_lateness  <= late_max_q;
			out_q.step_count      <= count_q;
		end
	end

endmodule

/* src/sts_checker.sv */
// port-level checks of the step timing statistics block and their bind
`include "step_timing_statistics_macros.svh"

module sts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          stats_valid,
	input logic                          stats_ready,
	input logic [sts_pkg::TimeWidth-1:0] min_step,
	input logic [sts_pkg::TimeWidth-1:0] max_step,
	input logic [sts_pkg::TimeWidth-1:0] min_round_trip,
	input logic [sts_pkg::TimeWidth-1:0] max_round_trip,
	input logic [sts_pkg::TimeWidth-1:0] step_count
);

	`STS_ASSERT_NEXT(a_out_held, stats_valid && !stats_ready, stats_valid)
	`STS_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready)
	`STS_ASSERT_NOW(a_count_nonzero, stats_valid, step_count != '0)
	`STS_ASSERT_NOW(a_min_le_max, stats_valid,
		(min_step <= max_step) && (min_round_trip <= max_round_trip))

endmodule

bind step_timing_statistics sts_checker u_sts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_valid   (sample.valid),
	.sample_ready   (sample.ready),
	.stats_valid    (stats.valid),
	.stats_ready    (stats.ready),
	.min_step       (stats.data.min_step),
	.max_step       (stats.data.max_step),
	.min_round_trip (stats.data.min_round_trip),
	.max_round_trip (stats.data.max_round_trip),
	.step_count     (stats.data.step_count)
);
